/* rtl/core/krt_pkg.sv */
`default_nettype none

package krt_pkg;

  // Width of a normalized name: four 64-bit words.
  localparam int KEY_W = 256;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_DUPLICATE = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic [7:0]  age_in;
    logic        gender_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] age_out;
    logic       gender_out;
  } out_item_t;

  // One table entry as it sits in the record memory.
  typedef struct packed {
    logic             valid;
    logic [7:0]       age;
    logic             gender;
    logic [KEY_W-1:0] key;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

`default_nettype wire

/* rtl/core/krt_ram.sv */
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/keyed_record_table_top.sv */
`default_nettype none

// Exact-match record table of ENTRIES records, each keyed by a 32-byte name
// and holding an 8-bit age and a 1-bit gender. A transaction on the input
// channel is an add, a search or a remove; every input transaction produces
// exactly one result transaction carrying a status and, on a successful
// search, the stored age and gender. Names are normalized on entry: every
// byte from the first zero byte onward, and byte 31 always, counts as zero.
// All records, with their valid marks, live in one record memory with a
// single read port, and each operation scans it one entry per cycle. A
// transaction passes through accept, a scan of every entry, and a finish
// step that writes back and posts the result once the output register has
// room. Only one operation is in flight at a time. After reset the block
// runs a clearing pass over the record memory, and in_stall stays high
// until it is done. A finished result sits in an output register, so the
// next transaction is accepted while the last result still waits to be
// taken.
module keyed_record_table_top #(
  parameter int ENTRIES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire krt_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output krt_pkg::out_item_t     out_data
);

  // Address bits of one entry, and a counter wide enough to hold ENTRIES.
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Control registers.
  logic [CW-1:0] cnt_r, cnt_nxt;          // clearing or read-issue counter
  logic          chk_vld_r, chk_vld_nxt;  // read data this cycle belongs to an entry
  logic [AW-1:0] chk_idx_r, chk_idx_nxt;  // entry whose data is on the read port
  logic          hit_r, hit_nxt;
  logic          free_fnd_r, free_fnd_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [1:0]                 kind_r;
  logic [krt_pkg::KEY_W-1:0]  key_r;
  logic [7:0]                 age_r;
  logic                       gender_r;
  logic [AW-1:0]              hit_idx_r, hit_idx_nxt;
  logic [7:0]                 hit_age_r, hit_age_nxt;
  logic                       hit_gender_r, hit_gender_nxt;
  logic [AW-1:0]              free_idx_r, free_idx_nxt;
  krt_pkg::out_item_t         out_data_r, out_data_nxt;

  // Record memory ports.
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  krt_pkg::rec_t              mem_wrec;
  logic [AW-1:0]              mem_raddr;
  logic [krt_pkg::REC_W-1:0]  mem_rdata;
  krt_pkg::rec_t              rd_rec;
  logic                       rd_match;

  logic                       in_fire;
  logic                       out_free;
  logic [krt_pkg::KEY_W-1:0]  raw_key;
  logic [krt_pkg::KEY_W-1:0]  norm_key;

  krt_ram #(
    .WIDTH (krt_pkg::REC_W),
    .DEPTH (ENTRIES)
  ) u_rec_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wrec),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The output register can take a new result when it is empty or when its
  // current result leaves in this cycle.
  assign out_free = !out_valid_r || !out_stall;

  // Name normalization. A byte survives only if it and every byte below it
  // are nonzero; byte 31 never survives. Each byte is decided on its own.
  assign raw_key = {in_data.key_word3, in_data.key_word2,
                    in_data.key_word1, in_data.key_word0};

  always_comb begin
    logic [31:0] nz;
    logic [31:0] msk;
    for (int b = 0; b < 32; b++) begin
      nz[b] = (raw_key[8*b +: 8] != 8'd0);
    end
    for (int b = 0; b < 32; b++) begin
      msk = 32'((64'd1 << (b + 1)) - 64'd1);
      if ((b < 31) && ((nz & msk) == msk)) begin
        norm_key[8*b +: 8] = raw_key[8*b +: 8];
      end else begin
        norm_key[8*b +: 8] = 8'd0;
      end
    end
  end

  assign rd_rec   = krt_pkg::rec_t'(mem_rdata);
  assign rd_match = rd_rec.valid && (rd_rec.key == key_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    hit_nxt        = hit_r;
    free_fnd_nxt   = free_fnd_r;
    hit_idx_nxt    = hit_idx_r;
    hit_age_nxt    = hit_age_r;
    hit_gender_nxt = hit_gender_r;
    free_idx_nxt   = free_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = cnt_r[AW-1:0];
    mem_wrec       = '0;
    mem_raddr      = cnt_r[AW-1:0];

    case (state_r)
      S_CLEAR: begin
        // Write an empty record into each entry in turn.
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        if (cnt_r == CW'(ENTRIES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          cnt_nxt      = '0;
          hit_nxt      = 1'b0;
          free_fnd_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; the data for the entry read in the
        // previous cycle is checked against the key at the same time.
        if (cnt_r != CW'(ENTRIES)) begin
          mem_raddr   = cnt_r[AW-1:0];
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = cnt_r[AW-1:0];
          cnt_nxt     = cnt_r + 1'b1;
        end
        if (chk_vld_r) begin
          if (rd_match && !hit_r) begin
            hit_nxt        = 1'b1;
            hit_idx_nxt    = chk_idx_r;
            hit_age_nxt    = rd_rec.age;
            hit_gender_nxt = rd_rec.gender;
          end
          // Entries are checked in ascending order, so the first free one
          // found is the lowest-numbered.
          if (!rd_rec.valid && !free_fnd_r) begin
            free_fnd_nxt = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (cnt_r == CW'(ENTRIES)) begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        // Write back and post the result together, once the output
        // register has room.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.status = krt_pkg::STAT_NOT_FOUND;
          case (kind_r)
            krt_pkg::KIND_ADD: begin
              if (hit_r) begin
                out_data_nxt.status = krt_pkg::STAT_DUPLICATE;
              end else if (free_fnd_r) begin
                mem_we          = 1'b1;
                mem_waddr       = free_idx_r;
                mem_wrec.valid  = 1'b1;
                mem_wrec.age    = age_r;
                mem_wrec.gender = gender_r;
                mem_wrec.key    = key_r;
                out_data_nxt.status = krt_pkg::STAT_OK;
              end else begin
                out_data_nxt.status = krt_pkg::STAT_FULL;
              end
            end
            krt_pkg::KIND_SEARCH: begin
              if (hit_r) begin
                out_data_nxt.status     = krt_pkg::STAT_OK;
                out_data_nxt.age_out    = hit_age_r;
                out_data_nxt.gender_out = hit_gender_r;
              end
            end
            krt_pkg::KIND_REMOVE: begin
              if (hit_r) begin
                // An all-zero record clears the valid mark.
                mem_we    = 1'b1;
                mem_waddr = hit_idx_r;
                out_data_nxt.status = krt_pkg::STAT_OK;
              end
            end
            default: begin
              out_data_nxt.status = krt_pkg::STAT_NOT_FOUND;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      chk_idx_r   <= '0;
      hit_r       <= 1'b0;
      free_fnd_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      chk_idx_r   <= chk_idx_nxt;
      hit_r       <= hit_nxt;
      free_fnd_r  <= free_fnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r   <= in_data.kind;
      key_r    <= norm_key;
      age_r    <= in_data.age_in;
      gender_r <= in_data.gender_in;
    end
    hit_idx_r    <= hit_idx_nxt;
    hit_age_r    <= hit_age_nxt;
    hit_gender_r <= hit_gender_nxt;
    free_idx_r   <= free_idx_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

`default_nettype wire

/* tb/krt_checker.sv */
`default_nettype none

module krt_checker #(
  parameter int ENTRIES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire krt_pkg::in_item_t in_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire krt_pkg::out_item_t out_data,
  input  wire logic              drain_done,
  output int                     pending,
  output int                     fail_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import krt_pkg::*;

  // Shadow copy of the record table.
  logic              rec_used   [ENTRIES];
  logic [KEY_W-1:0]  rec_name   [ENTRIES];
  logic [7:0]        rec_age    [ENTRIES];
  logic              rec_gender [ENTRIES];

  out_item_t expected_results[$];
  out_item_t predicted;
  out_item_t oldest;
  status_t   exp_status;
  status_t   got_status;
  int        mismatch_count = 0;

  initial pending = 0;

  assign fail_count = mismatch_count + (drain_done ? pending : 0);

  // A name ends at its first zero byte; byte 31 never counts.
  function automatic logic [KEY_W-1:0] canonical_name(in_item_t cmd);
    logic [KEY_W-1:0] raw;
    logic [KEY_W-1:0] name;
    logic             ended;
    raw   = {cmd.key_word3, cmd.key_word2, cmd.key_word1, cmd.key_word0};
    name  = '0;
    ended = 1'b0;
    for (int b = 0; b < 31; b++) begin
      if (raw[b*8 +: 8] == 8'h00) ended = 1'b1;
      if (!ended) name[b*8 +: 8] = raw[b*8 +: 8];
    end
    return name;
  endfunction

  task automatic apply_command(input in_item_t cmd, output out_item_t res);
    logic [KEY_W-1:0] name;
    int               hit;
    int               slot;
    name = canonical_name(cmd);
    hit  = -1;
    slot = -1;
    res  = '0;
    res.status = STAT_NOT_FOUND;
    for (int e = 0; e < ENTRIES; e++) begin
      if (hit < 0 && rec_used[e] && rec_name[e] == name) hit = e;
    end
    case (kind_t'(cmd.kind))
      KIND_ADD: begin
        if (hit >= 0) begin
          res.status = STAT_DUPLICATE;
        end else begin
          for (int e = 0; e < ENTRIES; e++) begin
            if (slot < 0 && !rec_used[e]) slot = e;
          end
          if (slot < 0) begin
            res.status = STAT_FULL;
          end else begin
            rec_used[slot]   = 1'b1;
            rec_name[slot]   = name;
            rec_age[slot]    = cmd.age_in;
            rec_gender[slot] = cmd.gender_in;
            res.status       = STAT_OK;
          end
        end
      end
      KIND_SEARCH: begin
        if (hit >= 0) begin
          res.status     = STAT_OK;
          res.age_out    = rec_age[hit];
          res.gender_out = rec_gender[hit];
        end
      end
      KIND_REMOVE: begin
        if (hit >= 0) begin
          rec_used[hit] = 1'b0;
          res.status    = STAT_OK;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic flag_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  // Results are checked before the input side is sampled so that a stray
  // result can never consume the expectation of a command taken this edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < ENTRIES; e++) rec_used[e] = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got_status = status_t'(out_data.status);
        if (expected_results.size() == 0) begin
          flag_failure($sformatf("%0t: unexpected result status=%s age=%0d gender=%0d",
                                 $realtime, got_status.name(),
                                 out_data.age_out, out_data.gender_out));
        end else begin
          oldest     = expected_results.pop_front();
          exp_status = status_t'(oldest.status);
          if (oldest.status !== out_data.status || oldest.age_out !== out_data.age_out ||
              oldest.gender_out !== out_data.gender_out) begin
            flag_failure({$sformatf("%0t: result mismatch expected status=%s age=%0d gender=%0d",
                                    $realtime, exp_status.name(), oldest.age_out,
                                    oldest.gender_out),
                          $sformatf(", got status=%s age=%0d gender=%0d",
                                    got_status.name(), out_data.age_out,
                                    out_data.gender_out)});
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_command(in_data, predicted);
        expected_results.push_back(predicted);
      end
    end
    pending = expected_results.size();
  end

endmodule

`default_nettype wire

/* tb/tb_keyed_record_table_top.sv */
`default_nettype none

module tb_keyed_record_table_top;

  timeunit 1ns;
  timeprecision 1ps;

  import krt_pkg::*;

  localparam int ENTRIES     = 16;
  // Each transaction keeps the block busy through its accept, scan and finish steps.
  localparam int LATENCY     = ENTRIES + 3;
  localparam int RANDOM_CMDS = 1700;
  // This leaves a wide margin over the slowest legal run before the run
  // is declared hung.
  localparam int CYCLE_LIMIT = 1000000;
  // More names than entries, so the table fills up and overflows.
  localparam int NAME_POOL   = 24;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      drain_done = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  int        pending;
  int        fail_count;
  int        cycle_count = 0;

  logic [KEY_W-1:0] name_pool [NAME_POOL];

  always #5 clk = ~clk;

  keyed_record_table_top #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // The checker sits beside the block, watches both channels, predicts
  // every result and reports how many things went wrong.
  krt_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .drain_done(drain_done),
    .pending   (pending),
    .fail_count(fail_count)
  );

  // The result side stalls on its own pattern. Every so often it picks a
  // new mode: never stalling, stalling half the time, stalling rarely, or
  // stalling in long regular stretches. Changes happen on the falling edge
  // so the block sees a settled value at the rising edge.
  int stall_mode = 0;
  int mode_left  = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= 1'($urandom_range(0, 1));
      2:       out_stall <= ($urandom_range(0, 7) == 0);
      default: out_stall <= ((mode_left % 40) < 25);
    endcase
  end

  // Position of the terminating zero byte; byte 31 always counts as zero.
  function automatic int name_length(logic [KEY_W-1:0] name);
    for (int b = 0; b < 31; b++) begin
      if (name[b*8 +: 8] == 8'h00) return b;
    end
    return 31;
  endfunction

  // Spell a clean name the way a host might: whatever follows the
  // terminator is often filled with junk, which the block must ignore.
  function automatic logic [KEY_W-1:0] loose_spelling(logic [KEY_W-1:0] name);
    logic [KEY_W-1:0] raw;
    int               len;
    raw = name;
    len = name_length(name);
    if ($urandom_range(0, 1) == 1) begin
      for (int b = len + 1; b < 32; b++) raw[b*8 +: 8] = 8'($urandom_range(0, 255));
      if (len == 31) raw[31*8 +: 8] = 8'($urandom_range(0, 255));
    end
    return raw;
  endfunction

  function automatic in_item_t build_command(kind_t kind, logic [KEY_W-1:0] raw,
                                             logic [7:0] age, logic gender);
    in_item_t cmd;
    cmd.kind      = kind;
    cmd.key_word0 = raw[63:0];
    cmd.key_word1 = raw[127:64];
    cmd.key_word2 = raw[191:128];
    cmd.key_word3 = raw[255:192];
    cmd.age_in    = age;
    cmd.gender_in = gender;
    return cmd;
  endfunction

  // Random transaction. The bias steers the mix toward filling the table,
  // keeping it steady, or draining it, so that both the full and the
  // empty corners come up often. A few transactions carry a fully random key.
  function automatic in_item_t random_command(int bias);
    logic [KEY_W-1:0] raw;
    kind_t            kind;
    int               roll;
    int               add_cut;
    int               search_cut;
    add_cut    = (bias == 0) ? 55 : (bias == 1) ? 35 : 15;
    search_cut = (bias == 0) ? 85 : (bias == 1) ? 70 : 45;
    roll = $urandom_range(0, 99);
    if (roll < add_cut) kind = KIND_ADD;
    else if (roll < search_cut) kind = KIND_SEARCH;
    else if (roll < 97) kind = KIND_REMOVE;
    else kind = KIND_UNUSED;
    if ($urandom_range(0, 15) == 0) begin
      for (int w = 0; w < 8; w++) raw[w*32 +: 32] = $urandom();
    end else begin
      raw = loose_spelling(name_pool[$urandom_range(0, NAME_POOL - 1)]);
    end
    return build_command(kind, raw, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
  endfunction

  // Present one transaction at the falling edge and hold it until the
  // block takes it. Valid stays high afterwards; the caller lowers it only
  // when a gap follows.
  task automatic send_command(in_item_t cmd);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Name pool: the empty name, a name that uses all 31 bytes, and random
  // names of mixed length. Some are prefixes of their neighbor, so keys
  // that differ only in their last byte are exercised.
  task automatic fill_name_pool();
    int len;
    name_pool[0] = '0;
    name_pool[1] = {8'h00, {31{8'hFF}}};
    for (int i = 2; i < NAME_POOL; i++) begin
      len = name_length(name_pool[i-1]);
      if (i % 5 == 0 && len > 1) begin
        name_pool[i] = name_pool[i-1];
        name_pool[i][(len-1)*8 +: 8] = 8'h00;
      end else begin
        name_pool[i] = '0;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 8);
        for (int b = 0; b < len; b++) name_pool[i][b*8 +: 8] = 8'($urandom_range(1, 255));
      end
    end
  endtask

  // Hang guard: the run is stopped if it goes on far longer than any
  // correct run could.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0] junk;
    int               burst_left;
    int               bias;
    int               bias_left;

    fill_name_pool();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The block holds in_stall through its clearing pass,
    // so the first transaction simply waits for it.
    // Remove on an empty table misses, and the unused kind changes nothing.
    send_command(build_command(KIND_REMOVE, '1, 8'hFF, 1'b1));
    for (int w = 0; w < 8; w++) junk[w*32 +: 32] = $urandom();
    send_command(build_command(KIND_UNUSED, junk, 8'hFF, 1'b1));
    // The empty name is an ordinary key.
    send_command(build_command(KIND_ADD, '0, 8'h00, 1'b0));
    // All-ones words: the name runs to byte 30 and byte 31 is dropped.
    send_command(build_command(KIND_ADD, '1, 8'hFF, 1'b1));
    send_command(build_command(KIND_SEARCH, {8'h00, {31{8'hFF}}}, 8'h00, 1'b0));
    // Same name with a different byte 31 is a duplicate.
    send_command(build_command(KIND_ADD, {8'h5A, {31{8'hFF}}}, 8'h07, 1'b0));
    // Junk after a leading zero still means the empty name.
    junk[7:0] = 8'h00;
    send_command(build_command(KIND_SEARCH, junk, 8'h11, 1'b1));
    // Fill the rest of the table, then overflow it.
    for (int i = 2; i < ENTRIES; i++) begin
      send_command(build_command(KIND_ADD, loose_spelling(name_pool[i]),
                                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    end
    send_command(build_command(KIND_ADD, name_pool[ENTRIES], 8'h22, 1'b1));
    // Duplicate on a full table reports the duplicate, not full.
    send_command(build_command(KIND_ADD, '1, 8'h33, 1'b0));
    // Free an entry in the middle; the next add must take that hole.
    send_command(build_command(KIND_REMOVE, loose_spelling(name_pool[5]), 8'h00, 1'b0));
    send_command(build_command(KIND_ADD, name_pool[ENTRIES + 1], 8'h44, 1'b1));

    // Random part: the sender works in bursts separated by gaps, with an
    // occasional long burst that runs without any idling.
    bias       = 0;
    bias_left  = $urandom_range(60, 150);
    burst_left = $urandom_range(1, 24);
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (bias_left == 0) begin
        bias      = $urandom_range(0, 2);
        bias_left = $urandom_range(60, 150);
      end
      bias_left--;
      send_command(random_command(bias));
      burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 30));
        burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
      end
    end
    idle_for(1);

    // Drain: wait for every predicted result, then give the block a few
    // transaction times more so any stray result would still show up.
    while (pending != 0) @(posedge clk);
    repeat (3 * LATENCY) @(posedge clk);
    drain_done = 1'b1;
    @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/krt_pkg.sv
rtl/core/krt_ram.sv
rtl/core/keyed_record_table_top.sv
tb/krt_checker.sv
tb/tb_keyed_record_table_top.sv
